// ===== rtl/core/sha1md_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the sha-1 digest core
// no dependencies; imported by sha1md_ctrl, sha1md_dp and the top level
package sha1md_pkg;

   // round constants
   localparam logic [31:0] K_ROUND0 = 32'h5a827999;
   localparam logic [31:0] K_ROUND1 = 32'h6ed9eba1;
   localparam logic [31:0] K_ROUND2 = 32'h8f1bbcdc;
   localparam logic [31:0] K_ROUND3 = 32'hca62c1d6;

   // initial chaining value
   localparam logic [31:0] H_INIT [5] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
   localparam logic [7:0] PAD_ZERO_BYTE = 8'h00;

   // counter limits
   localparam logic [5:0] FILL_LAST   = 6'd63;
   localparam logic [5:0] FILL_PAD_END = 6'd55;  // next byte lands at position 56
   localparam logic [6:0] ROUND_LAST  = 7'd79;
   localparam logic [6:0] ROUND_GRP1  = 7'd20;
   localparam logic [6:0] ROUND_GRP2  = 7'd40;
   localparam logic [6:0] ROUND_GRP3  = 7'd60;
   localparam logic [2:0] LEN_LAST    = 3'd7;
   localparam logic [2:0] WORD_LAST   = 3'd4;

   // byte source for the block shift line
   localparam logic [1:0] BSEL_DATA = 2'd0;
   localparam logic [1:0] BSEL_MARK = 2'd1;
   localparam logic [1:0] BSEL_ZERO = 2'd2;
   localparam logic [1:0] BSEL_LEN  = 2'd3;

   typedef struct packed {
      logic       put_en;      // shift one byte into the block
      logic [1:0] bsel;        // which byte
      logic [2:0] len_idx;     // length byte, 0 is most significant
      logic       count_en;    // add 8 to the bit count
      logic       comp_load;   // load working vars from chaining words
      logic       round_en;    // run one round
      logic [6:0] round_idx;
      logic       comp_add;    // fold working vars into chaining words
      logic       chain_init;  // start a new message
      logic [2:0] word_idx;    // digest word shown on the output
   } sha1md_cmd_type;

endpackage

// ===== rtl/core/sha1md_ctrl.sv =====
`timescale 1ns / 1ps
// controller for the sha-1 digest core: handshakes, fill count, padding and round sequencing
// depends on sha1md_pkg
module sha1md_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_byte_present,
   input  logic                      req_message_end,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_word_number,
   output logic                      rsp_final_word,
   output sha1md_pkg::sha1md_cmd_type cmd
);
   import sha1md_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MARK  = 3'd1;
   localparam logic [2:0] S_ZERO  = 3'd2;
   localparam logic [2:0] S_LEN   = 3'd3;
   localparam logic [2:0] S_ROUND = 3'd4;
   localparam logic [2:0] S_ADD   = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [2:0] ret_ff, ret_in;
   logic [5:0] fill_ff, fill_in;
   logic [6:0] round_ff, round_in;
   logic [2:0] len_ff, len_in;
   logic [2:0] word_ff, word_in;
   logic       phase_arm;
   logic [2:0] nxt;

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      fill_in   = fill_ff;
      round_in  = round_ff;
      len_in    = len_ff;
      word_in   = word_ff;
      phase_arm = 1'b0;
      nxt       = state_ff;
      cmd            = '0;
      cmd.bsel       = BSEL_DATA;
      cmd.len_idx    = len_ff;
      cmd.round_idx  = round_ff;
      cmd.word_idx   = word_ff;
      case (state_ff)
         S_IDLE: begin
            phase_arm = req_valid;
            if (req_valid) begin
               nxt          = req_message_end ? S_MARK : S_IDLE;
               cmd.put_en   = req_byte_present;
               cmd.count_en = req_byte_present;
            end
         end
         S_MARK, S_ZERO: begin
            phase_arm  = 1'b1;
            cmd.put_en = 1'b1;
            cmd.bsel   = (state_ff == S_MARK) ? BSEL_MARK : BSEL_ZERO;
            nxt        = (fill_ff == FILL_PAD_END) ? S_LEN : S_ZERO;
         end
         S_LEN: begin
            phase_arm  = 1'b1;
            cmd.put_en = 1'b1;
            cmd.bsel   = BSEL_LEN;
            len_in     = len_ff + 3'd1;
            nxt        = (len_ff == LEN_LAST) ? S_EMIT : S_LEN;
         end
         S_ROUND: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 7'd1;
            if (round_ff == ROUND_LAST) begin
               round_in = '0;
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            cmd.comp_add = 1'b1;
            state_in     = ret_ff;
         end
         S_EMIT: begin
            if (rsp_ready) begin
               word_in = word_ff + 3'd1;
               if (word_ff == WORD_LAST) begin
                  word_in        = '0;
                  cmd.chain_init = 1'b1;
                  state_in       = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a byte that completes the block starts a compression first
      if (phase_arm) begin
         if (cmd.put_en) begin
            fill_in = fill_ff + 6'd1;
         end
         if (cmd.put_en && (fill_ff == FILL_LAST)) begin
            cmd.comp_load = 1'b1;
            ret_in        = nxt;
            state_in      = S_ROUND;
         end else begin
            state_in = nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         fill_ff  <= '0;
         round_ff <= '0;
         len_ff   <= '0;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         fill_ff  <= fill_in;
         round_ff <= round_in;
         len_ff   <= len_in;
         word_ff  <= word_in;
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = (state_ff == S_EMIT);
   assign rsp_word_number = word_ff;
   assign rsp_final_word  = (word_ff == WORD_LAST);

endmodule

// ===== rtl/core/sha1md_dp.sv =====
`timescale 1ns / 1ps
// datapath for the sha-1 digest core: block shift line, round logic, chaining words, bit count
// depends on sha1md_pkg
module sha1md_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  sha1md_pkg::sha1md_cmd_type cmd,
   input  logic [7:0]                req_data_byte,
   output logic [31:0]               rsp_digest_word
);
   import sha1md_pkg::*;

   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] chain_ff [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [63:0] bits_ff;
   logic [7:0]  put_byte;
   logic [7:0]  len_byte;
   logic [31:0] sched_mix;
   logic [31:0] f_val, k_val, round_sum;

   // length byte 0 is the most significant byte of the bit count
   assign len_byte = bits_ff[{~cmd.len_idx, 3'b000} +: 8];

   always_comb begin
      case (cmd.bsel)
         BSEL_DATA: put_byte = req_data_byte;
         BSEL_MARK: put_byte = PAD_MARK_BYTE;
         BSEL_ZERO: put_byte = PAD_ZERO_BYTE;
         BSEL_LEN:  put_byte = len_byte;
         default:   put_byte = PAD_ZERO_BYTE;
      endcase
   end

   // w_ff[0] is the schedule word of the current round
   assign sched_mix = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         w_in[i] = w_ff[i];
      end
      if (cmd.put_en) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = {w_ff[i][23:0], w_ff[i+1][31:24]};
         end
         w_in[15] = {w_ff[15][23:0], put_byte};
      end else if (cmd.round_en) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[15] = {sched_mix[30:0], sched_mix[31]};
      end
   end

   always_comb begin
      if (cmd.round_idx < ROUND_GRP1) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K_ROUND0;
      end else if (cmd.round_idx < ROUND_GRP2) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_ROUND1;
      end else if (cmd.round_idx < ROUND_GRP3) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K_ROUND2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_ROUND3;
      end
      round_sum = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_ff[0];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) begin
         w_ff[i] <= w_in[i];
      end
      if (cmd.comp_load) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
         e_ff <= chain_ff[4];
      end else if (cmd.round_en) begin
         a_ff <= round_sum;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.chain_init) begin
         for (int i = 0; i < 5; i++) begin
            chain_ff[i] <= H_INIT[i];
         end
         bits_ff <= '0;
      end else begin
         if (cmd.comp_add) begin
            chain_ff[0] <= chain_ff[0] + a_ff;
            chain_ff[1] <= chain_ff[1] + b_ff;
            chain_ff[2] <= chain_ff[2] + c_ff;
            chain_ff[3] <= chain_ff[3] + d_ff;
            chain_ff[4] <= chain_ff[4] + e_ff;
         end
         if (cmd.count_en) begin
            bits_ff <= bits_ff + 64'd8;
         end
      end
   end

   assign rsp_digest_word = chain_ff[cmd.word_idx];

endmodule

// ===== rtl/core/sha1_message_digest.sv =====
`timescale 1ns / 1ps
// sha-1 digest over a byte stream; one byte word per accepted request
// a byte word that completes a 64-byte block starts a compression: 80 rounds
//   on the shared round unit, then an add step; no byte word is taken meanwhile
// end of message: 9 to 72 padding bytes go in at one byte per cycle, paused while a
//   block is compressed; then five digest words leave at up to one per cycle
// reset (synchronous): chaining words to the initial value, bit and fill counts cleared
module sha1_message_digest (
   input  logic        clock,
   input  logic        reset,
   // request channel: one message byte word per handshake
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_message_end,
   // response channel: five digest words per message
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_number,
   output logic        rsp_final_word
);
   import sha1md_pkg::*;

   // command bundle from the controller to the datapath
   sha1md_cmd_type cmd;

   // controller: idle/pad/round/emit sequencing and the fill count
   sha1md_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_present (req_byte_present),
      .req_message_end  (req_message_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word_number  (rsp_word_number),
      .rsp_final_word   (rsp_final_word),
      .cmd              (cmd)
   );

   // datapath: 16-word schedule shift line, working vars, chaining words
   sha1md_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_data_byte   (req_data_byte),
      .rsp_digest_word (rsp_digest_word)
   );

`ifndef SYNTHESIS
   // the block never takes input while digest words are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while digest pending");

   // a message end always starts padding, so input closes
   a_end_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_message_end) |=> !req_ready)
      else $error("input still open after message end");

   // after the last digest word the core is back to idle
   a_final_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_final_word) |=> (req_ready && !rsp_valid))
      else $error("core not idle after final digest word");

   // a byte word without a message end never makes digest words appear
   a_byte_no_output: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_message_end) |=> !rsp_valid)
      else $error("digest word without message end");
`endif

endmodule
